// File: rtl/core/sbsh_pkg.sv
// Shared types, constants and SHA-256 helper functions for the byte stream hasher.
package sbsh_pkg;

  localparam int WordW = 32;
  localparam int BufDepth = 16;
  localparam int BufAw = 4;
  localparam int CountW = 61;
  localparam logic [7:0] PadByte = 8'h80;

  // Request from the compression engine to the block memory.
  typedef struct packed {
    logic             we;
    logic [BufAw-1:0] waddr;
    logic [WordW-1:0] wdata;
    logic [BufAw-1:0] raddr_a;
    logic [BufAw-1:0] raddr_b;
  } sbsh_ram_req_t;

  typedef logic [7:0][WordW-1:0] sbsh_hash_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  // Initial hash values for a new message.
  function automatic sbsh_hash_t init_hash();
    sbsh_hash_t h;
    h[0] = 32'h6a09e667; h[1] = 32'hbb67ae85; h[2] = 32'h3c6ef372; h[3] = 32'ha54ff53a;
    h[4] = 32'h510e527f; h[5] = 32'h9b05688c; h[6] = 32'h1f83d9ab; h[7] = 32'h5be0cd19;
    return h;
  endfunction

  // Round constants.
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/core/sbsh_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
module sbsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/sbsh_core.sv
// SHA-256 compression engine; the message schedule is kept in place in the block memory.
module sbsh_core
  import sbsh_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sbsh_hash_t    hash_in,
  input  logic [31:0]   rdata_a,
  input  logic [31:0]   rdata_b,
  output sbsh_ram_req_t ram_req,
  output logic          busy,
  output logic          done,
  output sbsh_hash_t    hash_out
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_S0   = 3'd1;
  localparam logic [2:0] C_S1   = 3'd2;
  localparam logic [2:0] C_P0   = 3'd3;
  localparam logic [2:0] C_P1   = 3'd4;
  localparam logic [2:0] C_FIN  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  sbsh_hash_t  v_r, v_nxt;
  logic [31:0] x_r, x_nxt, y_r, y_nxt, w_r, w_nxt;
  logic [31:0] w_calc, t1, t2;

  // Schedule word: straight from memory in the first 16 rounds.
  assign w_calc = (rnd_r[5:4] == 2'b00) ? x_r :
                  x_r + small_sig0(rdata_a) + y_r + small_sig1(rdata_b);

  assign t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + round_k(rnd_r) + w_r;
  assign t2 = big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // Each round runs a schedule update (C_P0), then the round itself (C_P1).
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    v_nxt     = v_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    w_nxt     = w_r;
    ram_req   = '0;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          state_nxt = C_S0;
        end
      end
      C_S0: begin
        v_nxt           = hash_in;
        ram_req.raddr_a = 4'd0;
        state_nxt       = C_S1;
      end
      C_S1: begin
        x_nxt           = rdata_a;
        y_nxt           = rdata_b;
        ram_req.raddr_a = 4'd1;
        ram_req.raddr_b = 4'd14;
        rnd_nxt         = '0;
        state_nxt       = C_P0;
      end
      C_P0: begin
        w_nxt           = w_calc;
        ram_req.we      = (rnd_r[5:4] != 2'b00);
        ram_req.waddr   = rnd_r[3:0];
        ram_req.wdata   = w_calc;
        ram_req.raddr_a = rnd_r[3:0] + 4'd1;
        ram_req.raddr_b = rnd_r[3:0] + 4'd10;
        state_nxt       = C_P1;
      end
      C_P1: begin
        x_nxt           = rdata_a;
        y_nxt           = rdata_b;
        ram_req.raddr_a = rnd_r[3:0] + 4'd2;
        ram_req.raddr_b = rnd_r[3:0] + 4'd15;
        v_nxt[7]        = v_r[6];
        v_nxt[6]        = v_r[5];
        v_nxt[5]        = v_r[4];
        v_nxt[4]        = v_r[3] + t1;
        v_nxt[3]        = v_r[2];
        v_nxt[2]        = v_r[1];
        v_nxt[1]        = v_r[0];
        v_nxt[0]        = t1 + t2;
        rnd_nxt         = rnd_r + 6'd1;
        state_nxt       = (rnd_r == 6'd63) ? C_FIN : C_P0;
      end
      C_FIN: begin
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
    v_r <= v_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    w_r <= w_nxt;
  end

  // Feed-forward sum of the block's result.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      hash_out[j] = hash_in[j] + v_r[j];
    end
  end

  assign busy = (state_r != C_IDLE);
  assign done = (state_r == C_FIN);

endmodule

// File: rtl/core/sha256_byte_stream_hasher_top.sv
// Top level of the SHA-256 byte stream hasher: byte packing, padding and digest output.
//
//  Channel | Dir | Signals                    | Contents
//  in_     | in  | tvalid tready tdata tuser tlast | one message byte, byte flag, end flag
//  out_    | out | tvalid tready tdata        | eight 32-bit digest words
//
// The 64th byte of a block starts the compression engine, which loads the block, runs a
// schedule update and then a round for each of the 64 rounds over the dual-read block memory,
// and adds the feed-forward; no byte transaction is taken while it runs.
// An end transaction adds padding writes and one or two compressions.
// Reset is synchronous; it clears the control state and loads the initial hash values.
// A pending digest does not stop byte transactions; only the next digest waits for out_tready.
module sha256_byte_stream_hasher_top
  import sbsh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] has_byte
  input  logic         in_tlast,   // end_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata   // digest_word_0 [31:0] up to digest_word_7 [255:224]
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PAD      = 3'd1;
  localparam logic [2:0] S_ZERO     = 3'd2;
  localparam logic [2:0] S_LEN_HI   = 3'd3;
  localparam logic [2:0] S_LEN_LO   = 3'd4;
  localparam logic [2:0] S_CMP_GO   = 3'd5;
  localparam logic [2:0] S_CMP_WAIT = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  logic [2:0]        state_r, state_nxt, ret_r, ret_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [4:0]        z_r, z_nxt;
  logic              two_r, two_nxt;
  sbsh_hash_t        hash_r, hash_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [255:0]      out_data_r, out_data_nxt;
  logic              start;
  logic              in_fire;
  logic [5:0]        pos;
  logic [63:0]       bit_len;

  logic              top_we;
  logic [BufAw-1:0]  top_waddr;
  logic [31:0]       top_wdata;

  sbsh_ram_req_t     core_req;
  logic              core_busy, core_done;
  sbsh_hash_t        core_hash;
  logic [31:0]       rdata_a, rdata_b;

  // Place one byte big-endian in the word; the first byte of a word drops the old contents.
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] p,
                                           input logic [7:0] b);
    logic [31:0] r;
    case (p)
      2'd0:    r = {b, 24'h0};
      2'd1:    r = {w[31:24], b, 16'h0};
      2'd2:    r = {w[31:16], b, 8'h0};
      default: r = {w[31:8], b};
    endcase
    return r;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign pos       = cnt_r[5:0];
  assign bit_len   = {cnt_r, 3'b000};
  assign start     = (state_r == S_CMP_GO);

  // Message sequencer.
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cnt_nxt       = cnt_r;
    word_nxt      = word_r;
    z_nxt         = z_r;
    two_nxt       = two_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    top_we        = 1'b0;
    top_waddr     = pos[5:2];
    top_wdata     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser) begin
            word_nxt  = put_byte(word_r, pos[1:0], in_tdata);
            cnt_nxt   = cnt_r + 1'b1;
            top_we    = (pos[1:0] == 2'd3);
            top_wdata = word_nxt;
            if (pos == 6'd63) begin
              ret_nxt   = in_tlast ? S_PAD : S_IDLE;
              state_nxt = S_CMP_GO;
            end else if (in_tlast) begin
              state_nxt = S_PAD;
            end
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        top_we    = 1'b1;
        top_wdata = put_byte(word_r, pos[1:0], PadByte);
        z_nxt     = {1'b0, pos[5:2]} + 5'd1;
        two_nxt   = (pos[5:3] == 3'd7);
        state_nxt = S_ZERO;
      end
      S_ZERO: begin
        if (z_r[4]) begin
          if (two_r) begin
            two_nxt   = 1'b0;
            z_nxt     = '0;
            ret_nxt   = S_ZERO;
            state_nxt = S_CMP_GO;
          end else begin
            state_nxt = S_LEN_HI;
          end
        end else begin
          top_we    = 1'b1;
          top_waddr = z_r[3:0];
          z_nxt     = z_r + 5'd1;
        end
      end
      S_LEN_HI: begin
        top_we    = 1'b1;
        top_waddr = 4'd14;
        top_wdata = bit_len[63:32];
        state_nxt = S_LEN_LO;
      end
      S_LEN_LO: begin
        top_we    = 1'b1;
        top_waddr = 4'd15;
        top_wdata = bit_len[31:0];
        ret_nxt   = S_EMIT;
        state_nxt = S_CMP_GO;
      end
      S_CMP_GO: begin
        state_nxt = S_CMP_WAIT;
      end
      S_CMP_WAIT: begin
        if (core_done) begin
          hash_nxt  = core_hash;
          state_nxt = ret_r;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hash_r;
          hash_nxt      = init_hash();
          cnt_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      z_r         <= '0;
      two_r       <= 1'b0;
      hash_r      <= init_hash();
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      z_r         <= z_nxt;
      two_r       <= two_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
    word_r     <= word_nxt;
    out_data_r <= out_data_nxt;
  end

  // Block memory: the engine owns the write port while it runs.
  sbsh_ram #(
    .WIDTH(WordW),
    .DEPTH(BufDepth)
  ) u_ram (
    .clk    (clk),
    .we     (core_busy ? core_req.we : top_we),
    .waddr  (core_busy ? core_req.waddr : top_waddr),
    .wdata  (core_busy ? core_req.wdata : top_wdata),
    .raddr_a(core_req.raddr_a),
    .raddr_b(core_req.raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  sbsh_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .hash_in (hash_r),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .ram_req (core_req),
    .busy    (core_busy),
    .done    (core_done),
    .hash_out(core_hash)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The sequencer never writes the block memory while the engine runs.
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    core_busy |-> !top_we) else $error("block memory write clash");

  // The engine only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> (state_r == S_CMP_WAIT)) else $error("unexpected engine done");

  // No transaction is taken while a compression is in progress.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    core_busy |-> !in_tready) else $error("input accepted during compression");

  // A new digest never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && state_r == S_EMIT) |=> (state_r == S_EMIT))
    else $error("digest overwritten");

endmodule
